// ===== rtl/hms_pkg.sv =====
`default_nettype none

package hms_pkg;

    typedef struct packed {
        logic signed [31:0] element_value;
        logic               last_element;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_result;
        logic        [31:0] comparison_count;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_FRAME,
        ST_POP_CHECK,
        ST_INS_RD_KEY,
        ST_INS_WAIT_KEY,
        ST_INS_RD_PREV,
        ST_INS_WAIT_PREV,
        ST_INS_CMP,
        ST_INS_PLACE,
        ST_CPY_RD,
        ST_CPY_WR,
        ST_MRG_RD_I,
        ST_MRG_WAIT_I,
        ST_MRG_RD_J,
        ST_MRG_WAIT_J,
        ST_MRG_CMP,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } state_t;

    localparam logic [1:0] PH_SPLIT = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_MERGE = 2'd2;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd25;
    localparam logic [0:0]  REG_THRESHOLD   = 1'b0;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== rtl/hms_ram.sv =====
`default_nettype none

module hms_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/hybrid_merge_insertion_sort_top.sv =====
// hybrid merge/insertion sort
// s_ channel: one signed element per item; s_data.last_element closes the set
// and starts the sort. Elements beyond MAX_ELEMENTS are dropped (a marked one
// still starts the sort). Loading accepts one item per cycle.
// m_ channel: the sorted elements ascending, last_result on the final one,
// each with the comparison count of this sort (saturating).
// APB port: register 0 at address 0 is insertion_threshold (reset 25);
// write only while the block is idle.
// The sort runs on one element store and one merge scratch memory, each with
// a registered read. A merge pass copies each element into the scratch (read,
// write), then per element does two reads with their waits and one write back;
// an insertion shift is a read, a wait, and a compare with write, and each
// insertion key adds a key read, its wait and a final write of the key.
// Output: each result passes through a memory read, a wait and a hand-over;
// a stall (m_ready low) holds the current result.
// No input is accepted from the marked item until the last result is taken.
// Reset (aresetn low, synchronous) empties the store and restores the register.
`default_nettype none

module hybrid_merge_insertion_sort_top #(
    parameter int MAX_ELEMENTS = 64,
    parameter int STACK_DEPTH  = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire hms_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hms_pkg::out_item_t     m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = AW + 1;
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = SW + 1;
    localparam int TW = (AW > 8) ? AW : 8;
    localparam logic [CW-1:0] MAXN = CW'(MAX_ELEMENTS);

    hms_pkg::state_t state_reg, state_next;

    logic [7:0]    thr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   cmp_reg, cmp_next;

    // segment stack, registers per entry
    logic [AW-1:0] stk_lo_reg  [STACK_DEPTH];
    logic [AW-1:0] stk_hi_reg  [STACK_DEPTH];
    logic [AW-1:0] stk_mid_reg [STACK_DEPTH];
    logic [1:0]    stk_ph_reg  [STACK_DEPTH];
    logic [PW-1:0] sp_reg, sp_next;

    // working indices
    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [31:0]   key_reg, key_next, a_reg, a_next, b_reg, b_next;
    logic          pend_ins_reg, pend_ins_next;

    // memory ports
    logic          e_we, s_we;
    logic [AW-1:0] e_wa, e_ra, s_wa, s_ra;
    logic [31:0]   e_wd, s_wd, e_rd, s_rd;

    hms_ram #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_elem (
        .aclk(aclk), .we(e_we), .waddr(e_wa), .wdata(e_wd),
        .raddr(e_ra), .rdata(e_rd)
    );

    hms_ram #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_scr (
        .aclk(aclk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
        .raddr(s_ra), .rdata(s_rd)
    );

    // top frame
    logic [SW-1:0] top;
    logic [AW-1:0] f_lo, f_hi, f_mid, span;
    logic [1:0]    f_ph;
    assign top   = SW'(sp_reg - PW'(1));
    assign f_lo  = stk_lo_reg[top];
    assign f_hi  = stk_hi_reg[top];
    assign f_mid = stk_mid_reg[top];
    assign f_ph  = stk_ph_reg[top];
    assign span  = f_hi - f_lo;

    // segment small enough for insertion sort
    logic use_ins;
    assign use_ins = TW'(span) <= TW'(thr_reg);

    // stack operations
    logic          push_en, pop_en, upd_en;
    logic [AW-1:0] push_lo, push_hi, upd_mid;
    logic [1:0]    upd_ph;
    logic          stack_full;
    assign stack_full = (sp_reg >= PW'(STACK_DEPTH));

    logic          s_acc, m_acc, cfg_wr;
    assign s_acc  = s_valid && s_ready;
    assign m_acc  = m_valid && m_ready;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == hms_pkg::REG_THRESHOLD) ? {24'd0, thr_reg} : 32'd0;

    logic greater_ab, greater_pk;
    assign greater_ab = $signed(a_reg) > $signed(b_reg);
    assign greater_pk = $signed(e_rd) > $signed(key_reg);

    logic [31:0] cmp_inc;
    assign cmp_inc = (cmp_reg == hms_pkg::COUNT_MAX) ? cmp_reg : cmp_reg + 32'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hms_pkg::ST_LOAD:
                if (s_acc && s_data.last_element) state_next = hms_pkg::ST_FRAME;
            hms_pkg::ST_FRAME: begin
                if (pend_ins_reg) state_next = hms_pkg::ST_INS_RD_KEY;
                else if (sp_reg == '0) state_next = hms_pkg::ST_OUT_RD;
                else if (f_ph == hms_pkg::PH_SPLIT) begin
                    if (span != '0 && !use_ins)
                        state_next = stack_full ? hms_pkg::ST_INS_RD_KEY
                                                : hms_pkg::ST_FRAME;
                    else if (span != '0) state_next = hms_pkg::ST_INS_RD_KEY;
                end else if (f_ph == hms_pkg::PH_RIGHT) begin
                    if (stack_full && f_hi != f_mid + AW'(1))
                        state_next = hms_pkg::ST_INS_RD_KEY;
                end else begin
                    state_next = hms_pkg::ST_CPY_RD;
                end
            end
            hms_pkg::ST_INS_RD_KEY:
                state_next = (i_reg > CW'(hi_reg)) ? hms_pkg::ST_FRAME
                                                   : hms_pkg::ST_INS_WAIT_KEY;
            hms_pkg::ST_INS_WAIT_KEY: state_next = hms_pkg::ST_INS_RD_PREV;
            hms_pkg::ST_INS_RD_PREV:
                state_next = (j_reg > CW'(lo_reg)) ? hms_pkg::ST_INS_WAIT_PREV
                                                   : hms_pkg::ST_INS_PLACE;
            hms_pkg::ST_INS_WAIT_PREV: state_next = hms_pkg::ST_INS_CMP;
            hms_pkg::ST_INS_CMP:
                state_next = greater_pk ? hms_pkg::ST_INS_RD_PREV : hms_pkg::ST_INS_PLACE;
            hms_pkg::ST_INS_PLACE: state_next = hms_pkg::ST_INS_RD_KEY;
            hms_pkg::ST_CPY_RD:
                state_next = (k_reg > CW'(hi_reg)) ? hms_pkg::ST_MRG_RD_I
                                                   : hms_pkg::ST_CPY_WR;
            hms_pkg::ST_CPY_WR: state_next = hms_pkg::ST_CPY_RD;
            hms_pkg::ST_MRG_RD_I: begin
                if (k_reg > CW'(hi_reg)) state_next = hms_pkg::ST_FRAME;
                else state_next = hms_pkg::ST_MRG_WAIT_I;
            end
            hms_pkg::ST_MRG_WAIT_I: state_next = hms_pkg::ST_MRG_RD_J;
            hms_pkg::ST_MRG_RD_J: state_next = hms_pkg::ST_MRG_WAIT_J;
            hms_pkg::ST_MRG_WAIT_J: state_next = hms_pkg::ST_MRG_CMP;
            hms_pkg::ST_MRG_CMP: state_next = hms_pkg::ST_MRG_RD_I;
            hms_pkg::ST_OUT_RD: state_next = hms_pkg::ST_OUT_WAIT;
            hms_pkg::ST_OUT_WAIT: state_next = hms_pkg::ST_OUT_HOLD;
            hms_pkg::ST_OUT_HOLD:
                if (m_ready) state_next = (k_reg + CW'(1) >= cnt_reg) ? hms_pkg::ST_LOAD
                                                                      : hms_pkg::ST_OUT_RD;
            default: state_next = hms_pkg::ST_LOAD;
        endcase
    end

    // datapath and memory control
    logic i_ok, j_ok;
    assign i_ok = i_reg <= CW'(mid_reg);
    assign j_ok = j_reg <= CW'(hi_reg);

    always_comb begin
        cnt_next = cnt_reg; cmp_next = cmp_reg; sp_next = sp_reg;
        lo_next = lo_reg; hi_next = hi_reg; mid_next = mid_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg;
        key_next = key_reg; a_next = a_reg; b_next = b_reg;
        pend_ins_next = pend_ins_reg;
        push_en = 1'b0; pop_en = 1'b0; upd_en = 1'b0;
        push_lo = '0; push_hi = '0; upd_mid = f_mid; upd_ph = f_ph;
        e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
        s_ready = 1'b0; m_valid = 1'b0;
        m_data.sorted_value = e_rd;
        m_data.last_result = (k_reg + CW'(1) >= cnt_reg);
        m_data.comparison_count = cmp_reg;
        case (state_reg)
            hms_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (s_acc) begin
                    if (cnt_reg == '0) cmp_next = '0;
                    if (cnt_reg < MAXN) begin
                        e_we = 1'b1; e_wa = AW'(cnt_reg); e_wd = s_data.element_value;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (s_data.last_element) begin
                        push_en = 1'b1; push_lo = '0;
                        push_hi = (cnt_reg < MAXN) ? AW'(cnt_reg) : AW'(cnt_reg - CW'(1));
                    end
                end
            end
            hms_pkg::ST_FRAME: begin
                pend_ins_next = 1'b0;
                k_next = '0;
                if (!pend_ins_reg && sp_reg != '0) begin
                    if (f_ph == hms_pkg::PH_SPLIT) begin
                        if (span == '0) pop_en = 1'b1;
                        else if (use_ins) begin
                            pop_en = 1'b1; lo_next = f_lo; hi_next = f_hi;
                            i_next = CW'(f_lo) + CW'(1);
                        end else begin
                            upd_en = 1'b1; upd_ph = hms_pkg::PH_RIGHT;
                            upd_mid = f_lo + (span >> 1);
                            if (stack_full) begin
                                lo_next = f_lo; hi_next = f_lo + (span >> 1);
                                i_next = CW'(f_lo) + CW'(1);
                            end else begin
                                push_en = 1'b1; push_lo = f_lo;
                                push_hi = f_lo + (span >> 1);
                            end
                        end
                    end else if (f_ph == hms_pkg::PH_RIGHT) begin
                        upd_en = 1'b1; upd_ph = hms_pkg::PH_MERGE;
                        if (stack_full) begin
                            lo_next = f_mid + AW'(1); hi_next = f_hi;
                            i_next = CW'(f_mid) + CW'(2);
                        end else begin
                            push_en = 1'b1; push_lo = f_mid + AW'(1); push_hi = f_hi;
                        end
                    end else begin
                        pop_en = 1'b1;
                        lo_next = f_lo; mid_next = f_mid; hi_next = f_hi;
                        k_next = CW'(f_lo);
                    end
                end
            end
            hms_pkg::ST_INS_RD_KEY: begin
                e_ra = AW'(i_reg); j_next = i_reg;
            end
            hms_pkg::ST_INS_WAIT_KEY: key_next = e_rd;
            hms_pkg::ST_INS_RD_PREV: e_ra = AW'(j_reg - CW'(1));
            // keep the address so the previous element is still on e_rd
            hms_pkg::ST_INS_WAIT_PREV: e_ra = AW'(j_reg - CW'(1));
            hms_pkg::ST_INS_CMP: begin
                if (greater_pk) begin
                    cmp_next = cmp_inc;
                    e_we = 1'b1; e_wa = AW'(j_reg); e_wd = e_rd;
                    j_next = j_reg - CW'(1);
                end
            end
            hms_pkg::ST_INS_PLACE: begin
                e_we = 1'b1; e_wa = AW'(j_reg); e_wd = key_reg;
                i_next = i_reg + CW'(1);
            end
            hms_pkg::ST_CPY_RD: begin
                e_ra = AW'(k_reg);
                if (k_reg > CW'(hi_reg)) begin
                    i_next = CW'(lo_reg); j_next = CW'(mid_reg) + CW'(1);
                    k_next = CW'(lo_reg);
                end
            end
            hms_pkg::ST_CPY_WR: begin
                s_we = 1'b1; s_wa = AW'(k_reg); s_wd = e_rd;
                k_next = k_reg + CW'(1);
            end
            hms_pkg::ST_MRG_RD_I: s_ra = AW'(i_reg);
            hms_pkg::ST_MRG_WAIT_I: a_next = s_rd;
            hms_pkg::ST_MRG_RD_J: s_ra = AW'(j_reg);
            hms_pkg::ST_MRG_WAIT_J: b_next = s_rd;
            hms_pkg::ST_MRG_CMP: begin
                e_we = 1'b1; e_wa = AW'(k_reg);
                k_next = k_reg + CW'(1);
                if (i_ok && j_ok) begin
                    cmp_next = cmp_inc;
                    if (!greater_ab) begin e_wd = a_reg; i_next = i_reg + CW'(1); end
                    else begin e_wd = b_reg; j_next = j_reg + CW'(1); end
                end else if (i_ok) begin
                    e_wd = a_reg; i_next = i_reg + CW'(1);
                end else begin
                    e_wd = b_reg; j_next = j_reg + CW'(1);
                end
            end
            hms_pkg::ST_OUT_RD: e_ra = AW'(k_reg);
            hms_pkg::ST_OUT_WAIT: a_next = e_rd;
            hms_pkg::ST_OUT_HOLD: begin
                m_valid = 1'b1;
                m_data.sorted_value = a_reg;
                if (m_ready) begin
                    k_next = k_reg + CW'(1);
                    if (k_reg + CW'(1) >= cnt_reg) cnt_next = '0;
                end
            end
            default: ;
        endcase
        if (pop_en && !upd_en) sp_next = sp_reg - PW'(1);
        if (push_en) sp_next = sp_reg + PW'(1);
        if (state_reg == hms_pkg::ST_FRAME && stack_full && upd_en
            && upd_ph == hms_pkg::PH_RIGHT)
            pend_ins_next = 1'b0;
        if (state_reg == hms_pkg::ST_FRAME && !pend_ins_reg && sp_reg != '0
            && f_ph == hms_pkg::PH_RIGHT && stack_full && f_hi == f_mid + AW'(1))
            pend_ins_next = 1'b0;
    end

    // frame register writes
    always_ff @(posedge aclk) begin
        if (upd_en) begin
            stk_mid_reg[top] <= upd_mid;
            stk_ph_reg[top]  <= upd_ph;
        end
        if (push_en) begin
            stk_lo_reg[SW'(sp_reg)]  <= push_lo;
            stk_hi_reg[SW'(sp_reg)]  <= push_hi;
            stk_mid_reg[SW'(sp_reg)] <= push_lo;
            stk_ph_reg[SW'(sp_reg)]  <= hms_pkg::PH_SPLIT;
        end
    end

    // control and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hms_pkg::ST_LOAD;
            thr_reg <= hms_pkg::THRESHOLD_RESET;
            cnt_reg <= '0; cmp_reg <= '0; sp_reg <= '0; k_reg <= '0;
            pend_ins_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && paddr[2] == hms_pkg::REG_THRESHOLD) thr_reg <= pwdata[7:0];
            cnt_reg <= cnt_next; cmp_reg <= cmp_next; sp_reg <= sp_next;
            k_reg <= k_next; pend_ins_reg <= pend_ins_next;
        end
        lo_reg <= lo_next; hi_reg <= hi_next; mid_reg <= mid_next;
        i_reg <= i_next; j_reg <= j_next;
        key_reg <= key_next; a_reg <= a_next; b_reg <= b_next;
    end

    // checks
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= PW'(STACK_DEPTH)) else $error("segment stack overflow");
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("load open during output");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAXN) else $error("element count beyond store");
    a_out_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != '0) else $error("result with empty store");

endmodule

`default_nettype wire
